@@ design/lsab_pkg.sv @@
// lsab_pkg: shared widths, constants, types and the divider step for the angle bin pipeline
`timescale 1ns / 1ps
package lsab_pkg;

	localparam int ANGLE_BINS  = 360;
	localparam int DIST_W      = 14;
	localparam int BIN_W       = 9;
	localparam int RAW_W       = 16;
	localparam int IDX_W       = 8;
	localparam int CNT_W       = 8;
	localparam int DIFF_W      = 17;
	localparam int PROD_W      = IDX_W + 1 + DIFF_W;
	localparam int QUO_W       = 18;
	localparam int ANGLE_W     = 20;
	localparam int STEPS_PER_STAGE = 3;
	localparam int DIV_STAGES  = QUO_W / STEPS_PER_STAGE;

	localparam logic [DIST_W-1:0] MIN_DIST_RESET = 14'd40;
	localparam logic [DIST_W-1:0] MAX_DIST_RESET = 14'd2000;

	// configuration register indexes
	localparam logic REG_MIN_DISTANCE = 1'b0;
	localparam logic REG_MAX_DISTANCE = 1'b1;

	typedef struct packed {
		logic [BIN_W-1:0]  base;
		logic              neg;
		logic              zoff;
		logic [CNT_W-1:0]  divr;
		logic [CNT_W-1:0]  rem;
		logic [QUO_W-1:0]  num;
		logic [DIST_W-1:0] band_dist;
	} div_t;

	typedef struct packed {
		logic              write_valid;
		logic [BIN_W-1:0]  bin_index;
		logic [DIST_W-1:0] bin_distance;
		logic              angle_out_of_range;
	} result_t;

	// restoring division, quotient bits shift in at the bottom of num
	function automatic div_t div_steps(input div_t d);
		div_t           r;
		logic [CNT_W:0] t;
		r = d;
		for (int i = 0; i < STEPS_PER_STAGE; i++) begin
			t     = {r.rem, r.num[QUO_W-1]};
			r.num = {r.num[QUO_W-2:0], 1'b0};
			if (t >= {1'b0, r.divr}) begin
				t        = t - {1'b0, r.divr};
				r.num[0] = 1'b1;
			end
			r.rem = t[CNT_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ design/lsab_if.sv @@
// lsab_if: valid/ready channels for samples in and bin writes out
`timescale 1ns / 1ps
interface lsab_in_if;
	logic                          valid;
	logic                          ready;
	logic [lsab_pkg::RAW_W-1:0]    raw_sample;
	logic [lsab_pkg::IDX_W-1:0]    sample_index;
	logic [lsab_pkg::RAW_W-1:0]    start_angle_raw;
	logic [lsab_pkg::RAW_W-1:0]    end_angle_raw;
	logic [lsab_pkg::CNT_W-1:0]    sample_count;

	modport source (output valid, raw_sample, sample_index, start_angle_raw, end_angle_raw,
		sample_count, input ready);
	modport sink (input valid, raw_sample, sample_index, start_angle_raw, end_angle_raw,
		sample_count, output ready);
endinterface

interface lsab_out_if;
	logic                          valid;
	logic                          ready;
	logic                          write_valid;
	logic [lsab_pkg::BIN_W-1:0]    bin_index;
	logic [lsab_pkg::DIST_W-1:0]   bin_distance;
	logic                          angle_out_of_range;

	modport source (output valid, write_valid, bin_index, bin_distance, angle_out_of_range,
		input ready);
	modport sink (input valid, write_valid, bin_index, bin_distance, angle_out_of_range,
		output ready);
endinterface

@@ design/lidar_sample_to_angle_bin.sv @@
// A sample beat goes through stage 1, stage 2, the divider and the output register.
// Throughput: one beat per cycle without stall; multiply, abs/scale, six divider stages
// of three quotient bits each and the output register each hold one sample.
// Every stage moves on when it or the stage after it is free, so bubbles fill under stall.
// Reset clears all stage valid bits and loads min_distance 40, max_distance 2000.
`timescale 1ns / 1ps
module lidar_sample_to_angle_bin (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [lsab_pkg::DIST_W-1:0]   cfg_wdata,
	lsab_in_if.sink                       in_ch,
	lsab_out_if.source                    out_ch
);

	localparam int NS = lsab_pkg::DIV_STAGES;

	logic [lsab_pkg::DIST_W-1:0] min_dist_q, max_dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dist_q <= lsab_pkg::MIN_DIST_RESET;
			max_dist_q <= lsab_pkg::MAX_DIST_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				lsab_pkg::REG_MIN_DISTANCE: min_dist_q <= cfg_wdata;
				lsab_pkg::REG_MAX_DISTANCE: max_dist_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// stage enables, back to front
	logic          en_s1, en_s2, en_out;
	logic [NS-1:0] en_dv;
	logic          v_s1, v_s2, out_valid_q;
	logic [NS-1:0] v_dv;

	always_comb begin
		en_out = !out_valid_q || out_ch.ready;
		en_dv[NS-1] = !v_dv[NS-1] || en_out;
		for (int k = NS - 2; k >= 0; k--) begin
			en_dv[k] = !v_dv[k] || en_dv[k+1];
		end
		en_s2 = !v_s2 || en_dv[0];
		en_s1 = !v_s1 || en_s2;
	end

	assign in_ch.ready = en_s1;

	// stage 1: distance band, base angle, index times angle span
	logic [lsab_pkg::BIN_W-1:0]         base_s1;
	logic signed [lsab_pkg::PROD_W-1:0] prod_s1;
	logic                               zoff_s1;
	logic [lsab_pkg::CNT_W-1:0]         divr_s1;
	logic [lsab_pkg::DIST_W-1:0]        dist_s1;

	logic [lsab_pkg::DIST_W-1:0]        dist_in;
	logic signed [lsab_pkg::DIFF_W-1:0] diff_in;
	logic                               zoff_in;

	always_comb begin
		dist_in = in_ch.raw_sample[lsab_pkg::RAW_W-1:2];
		diff_in = $signed({2'b00, in_ch.end_angle_raw[lsab_pkg::RAW_W-1:1]})
			- $signed({2'b00, in_ch.start_angle_raw[lsab_pkg::RAW_W-1:1]});
		zoff_in = in_ch.sample_count <= lsab_pkg::CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_ch.valid) begin
			base_s1 <= in_ch.start_angle_raw[lsab_pkg::RAW_W-1:7];
			prod_s1 <= $signed({1'b0, in_ch.sample_index}) * diff_in;
			zoff_s1 <= zoff_in;
			divr_s1 <= zoff_in ? lsab_pkg::CNT_W'(1)
				: in_ch.sample_count - lsab_pkg::CNT_W'(1);
			dist_s1 <= (dist_in >= min_dist_q && dist_in <= max_dist_q)
				? dist_in : '0;
		end
	end

	// stage 2: magnitude of the product scaled down by 64, sign kept aside
	lsab_pkg::div_t                     dv_s2;
	logic [lsab_pkg::PROD_W-1:0]        mag_s1;

	assign mag_s1 = prod_s1[lsab_pkg::PROD_W-1] ? lsab_pkg::PROD_W'(-prod_s1)
		: lsab_pkg::PROD_W'(prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			dv_s2.base      <= base_s1;
			dv_s2.neg       <= prod_s1[lsab_pkg::PROD_W-1];
			dv_s2.zoff      <= zoff_s1;
			dv_s2.divr      <= divr_s1;
			dv_s2.rem       <= '0;
			dv_s2.num       <= lsab_pkg::QUO_W'(mag_s1[lsab_pkg::PROD_W-1:6]);
			dv_s2.band_dist <= dist_s1;
		end
	end

	// stages 3 to 8: divide by count minus one
	lsab_pkg::div_t dv_s [NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_dv <= '0;
		end else begin
			if (en_dv[0]) v_dv[0] <= v_s2;
			for (int k = 1; k < NS; k++) begin
				if (en_dv[k]) v_dv[k] <= v_dv[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_dv[0] && v_s2) dv_s[0] <= lsab_pkg::div_steps(dv_s2);
		for (int k = 1; k < NS; k++) begin
			if (en_dv[k] && v_dv[k-1]) dv_s[k] <= lsab_pkg::div_steps(dv_s[k-1]);
		end
	end

	// final: signed offset plus base, range check, output register
	lsab_pkg::div_t                      dv_last;
	logic signed [lsab_pkg::ANGLE_W-1:0] offset_d, angle_d;
	logic                                inside_d;
	lsab_pkg::result_t                   res_d, out_q;

	always_comb begin
		dv_last  = dv_s[NS-1];
		offset_d = $signed({2'b00, dv_last.num});
		if (dv_last.zoff) begin
			offset_d = '0;
		end else if (dv_last.neg) begin
			offset_d = -offset_d;
		end
		angle_d  = $signed({{(lsab_pkg::ANGLE_W - lsab_pkg::BIN_W){1'b0}}, dv_last.base})
			+ offset_d;
		inside_d = !angle_d[lsab_pkg::ANGLE_W-1]
			&& angle_d < lsab_pkg::ANGLE_W'(lsab_pkg::ANGLE_BINS);
		res_d.write_valid        = inside_d;
		res_d.bin_index          = inside_d ? angle_d[lsab_pkg::BIN_W-1:0] : '0;
		res_d.bin_distance       = inside_d ? dv_last.band_dist : '0;
		res_d.angle_out_of_range = !inside_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= v_dv[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_dv[NS-1]) out_q <= res_d;
	end

	assign out_ch.valid              = out_valid_q;
	assign out_ch.write_valid        = out_q.write_valid;
	assign out_ch.bin_index          = out_q.bin_index;
	assign out_ch.bin_distance       = out_q.bin_distance;
	assign out_ch.angle_out_of_range = out_q.angle_out_of_range;

	// input only backs up when every stage is full and the output beat is held
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> (out_ch.valid && !out_ch.ready && v_s1 && v_s2 && (&v_dv)))
		else $error("input blocked with a free stage");

	a_flag_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.write_valid != out_ch.angle_out_of_range))
		else $error("write_valid and out-of-range flag disagree");

	a_flagged_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.angle_out_of_range)
		|-> (out_ch.bin_index == '0 && out_ch.bin_distance == '0))
		else $error("flagged beat carries nonzero fields");

	a_bin_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.write_valid)
		|-> (out_ch.bin_index < lsab_pkg::BIN_W'(lsab_pkg::ANGLE_BINS)))
		else $error("written bin beyond bin count");

endmodule
